>>> src/greedy_nearest_triangle_order_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy triangle ordering block
// Clocked, reset-qualified property helpers for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef GREEDY_NEAREST_TRIANGLE_ORDER_MACROS_SVH
`define GREEDY_NEAREST_TRIANGLE_ORDER_MACROS_SVH

// Check a consequent in the same cycle as the antecedent.
`define GNTO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after the antecedent.
`define GNTO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gnto_pkg.sv
// ----------------------------------------------------------------------------
// gnto_pkg
// Shared types and constants for the greedy nearest-triangle ordering block.
// ----------------------------------------------------------------------------
package gnto_pkg;

    localparam int FIELD_W     = 16;  // width of each coordinate field on the port
    localparam int COORD_MAX_W = 24;  // widest internal coordinate supported
    localparam int TRI_IDX_W   = 6;   // triangle index width on the port and tags
    localparam int WEIGHT_W    = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int COORDS      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WEIGHT = 1'b1;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic signed [FIELD_W-1:0] tex_u;
        logic signed [FIELD_W-1:0] tex_v;
        logic                      load_end;
    } t_vertex;

    typedef struct packed {
        logic [TRI_IDX_W-1:0] triangle_index;
        logic                 order_end;
        logic                 overflow;
    } t_result;

    // One corner-pair read issued into the cost pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [TRI_IDX_W-1:0] j;
    } t_tag;

    // A finished candidate cost leaving the cost pipeline.
    typedef struct packed {
        logic                 valid;
        logic [TRI_IDX_W-1:0] j;
    } t_cand;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN
    } t_state;

endpackage

>>> src/gnto_store.sv
// ----------------------------------------------------------------------------
// gnto_store
// Vertex coordinate memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gnto_store #(
    parameter int DEPTH = 192,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> src/gnto_cost.sv
// ----------------------------------------------------------------------------
// gnto_cost
// Weighted SAD pipeline: one corner pair per cycle, accumulated per candidate.
// ----------------------------------------------------------------------------
module gnto_cost #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [gnto_pkg::WEIGHT_W-1:0]  i_pos_weight,
    input  logic [gnto_pkg::WEIGHT_W-1:0]  i_tex_weight,
    input  gnto_pkg::t_tag                 i_issue,
    input  logic [5*COORD_BITS-1:0]        i_rdata_a,
    input  logic [5*COORD_BITS-1:0]        i_rdata_b,
    output gnto_pkg::t_cand                o_cand,
    output logic [COORD_BITS+8:0]          o_cand_cost,
    output logic                           o_pending
);

    localparam int PS_W   = COORD_BITS + 2;
    localparam int TS_W   = COORD_BITS + 1;
    localparam int CRN_W  = COORD_BITS + 7;
    localparam int COST_W = COORD_BITS + 9;

    gnto_pkg::t_tag r_t1, r_t2, r_t3, r_t4;
    gnto_pkg::t_cand r_cand;

    logic [COORD_BITS-1:0] abs_d [gnto_pkg::COORDS];
    logic [COORD_BITS-1:0] r_abs [gnto_pkg::COORDS];
    logic [PS_W-1:0]       r_psum;
    logic [TS_W-1:0]       r_tsum;
    logic [CRN_W-1:0]      r_corner;
    logic [COST_W-1:0]     r_acc;
    logic [COST_W-1:0]     r_cand_cost;
    logic [COST_W-1:0]     acc_sum;

    // tags follow the data; the first stage lines up with the memory output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_t3   <= '0;
            r_t4   <= '0;
            r_cand <= '0;
        end else begin
            r_t1         <= i_issue;
            r_t2         <= r_t1;
            r_t3         <= r_t2;
            r_t4         <= r_t3;
            r_cand.valid <= r_t4.valid & r_t4.last;
            r_cand.j     <= r_t4.j;
        end
    end

    always_comb begin
        logic signed [COORD_BITS:0] d;
        for (int k = 0; k < gnto_pkg::COORDS; k++) begin
            d = $signed({i_rdata_a[k*COORD_BITS+COORD_BITS-1],
                         i_rdata_a[k*COORD_BITS +: COORD_BITS]})
              - $signed({i_rdata_b[k*COORD_BITS+COORD_BITS-1],
                         i_rdata_b[k*COORD_BITS +: COORD_BITS]});
            abs_d[k] = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
        end
    end

    assign acc_sum = (r_t4.first ? '0 : r_acc) + COST_W'(r_corner);

    always_ff @(posedge i_clk) begin
        r_abs    <= abs_d;
        r_psum   <= PS_W'(r_abs[0]) + PS_W'(r_abs[1]) + PS_W'(r_abs[2]);
        r_tsum   <= TS_W'(r_abs[3]) + TS_W'(r_abs[4]);
        r_corner <= CRN_W'(r_psum) * CRN_W'(i_pos_weight)
                  + CRN_W'(r_tsum) * CRN_W'(i_tex_weight);
        if (r_t4.valid) begin
            r_acc       <= acc_sum;
            r_cand_cost <= acc_sum;
        end
    end

    assign o_cand      = r_cand;
    assign o_cand_cost = r_cand_cost;
    assign o_pending   = r_t1.valid | r_t2.valid | r_t3.valid | r_t4.valid | r_cand.valid;

endmodule

>>> src/greedy_nearest_triangle_order.sv
// ----------------------------------------------------------------------------
// greedy_nearest_triangle_order
// Loads triangle vertices, then emits triangle indices in greedy order of
// smallest weighted sum of absolute corner differences to the previous pick.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Beat
//  -------   ---------  --------------------------  ------------------------
//  vertex    in         start & !busy               i_vertex (t_vertex)
//  result    out        o_strobe, one cycle, no     o_result (t_result)
//                       back-pressure
//  config    in         i_cfg_we, no wait           i_cfg_idx, i_cfg_data
//
//  A vertex beat without load_end is accepted without a wait; busy stays low.
//  The load_end beat emits triangle 0 next cycle if a whole triangle was
//  loaded; each further pick scans every unused candidate corner by corner
//  (one corner pair read from the two store read ports per cycle), passes
//  over used ones, waits for the cost pipeline to drain, then emits the pick.
//  Synchronous active-low reset clears control state and restores both weights
//  to 1; the coordinate store is not cleared and only written entries are read.
//  The result side cannot stall: each beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module greedy_nearest_triangle_order #(
    parameter int MAX_TRIANGLES = 64,
    parameter int COORD_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gnto_pkg::t_vertex                i_vertex,
    output logic                             o_strobe,
    output gnto_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [gnto_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gnto_pkg::WEIGHT_W-1:0]    i_cfg_data
);

    localparam int VCAP   = 3 * MAX_TRIANGLES;
    localparam int AW     = $clog2(VCAP);
    localparam int TW     = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int NW     = $clog2(MAX_TRIANGLES + 1);
    localparam int DW     = 5 * COORD_BITS;
    localparam int COST_W = COORD_BITS + 9;
    localparam int PAD_W  = gnto_pkg::COORD_MAX_W - gnto_pkg::FIELD_W;

    gnto_pkg::t_state  r_state, n_state;
    logic [NW-1:0]     r_ntri, n_ntri;         // whole triangles loaded
    logic [1:0]        r_phase, n_phase;       // corner slot of the next vertex
    logic              r_ovf, n_ovf;           // dropped a vertex this load
    logic              r_res_ovf, n_res_ovf;   // overflow flag of this ordering
    logic [MAX_TRIANGLES-1:0] r_used, n_used;
    logic [TW-1:0]     r_cur, n_cur;
    logic [TW-1:0]     r_j, n_j;
    logic [1:0]        r_c, n_c;
    logic [NW-1:0]     r_placed, n_placed;
    logic              r_found, n_found;
    logic [TW-1:0]     r_best, n_best;
    logic [COST_W-1:0] r_best_cost, n_best_cost;
    logic [gnto_pkg::WEIGHT_W-1:0] r_posw, n_posw, r_texw, n_texw;
    logic              r_strobe, n_strobe;
    gnto_pkg::t_result r_result, n_result;

    logic              accept;
    logic              full;
    logic              last_j;
    logic [NW-1:0]     tri_total;
    logic              ovf_total;
    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
    logic [DW-1:0]     wr_data, rd_data_a, rd_data_b;
    gnto_pkg::t_tag    issue;
    gnto_pkg::t_cand   cand;
    logic [COST_W-1:0] cand_cost;
    logic              pending;
    logic [gnto_pkg::FIELD_W-1:0] fields [gnto_pkg::COORDS];

    assign busy     = (r_state != gnto_pkg::ST_LOAD);
    assign accept   = start & ~busy;
    assign full     = (r_ntri == NW'(MAX_TRIANGLES));
    assign last_j   = (r_j == TW'(r_ntri - NW'(1)));
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Store addresses: vertex = triangle*3 + corner.
    assign wr_addr   = AW'({r_ntri, 1'b0}) + AW'(r_ntri) + AW'(r_phase);
    assign rd_addr_a = AW'({r_cur, 1'b0}) + AW'(r_cur) + AW'(r_c);
    assign rd_addr_b = AW'({r_j, 1'b0}) + AW'(r_j) + AW'(r_c);

    // Narrow or widen each field to the internal coordinate width; a field
    // wider than the internal width keeps its low bits as a signed value, a
    // narrower field is taken as an unsigned value.
    always_comb begin
        logic [gnto_pkg::COORD_MAX_W-1:0] ext;
        fields[0] = i_vertex.pos_x;
        fields[1] = i_vertex.pos_y;
        fields[2] = i_vertex.pos_z;
        fields[3] = i_vertex.tex_u;
        fields[4] = i_vertex.tex_v;
        wr_data   = '0;
        for (int k = 0; k < gnto_pkg::COORDS; k++) begin
            ext = {{PAD_W{1'b0}}, fields[k]};
            wr_data[k*COORD_BITS +: COORD_BITS] = ext[COORD_BITS-1:0];
        end
    end

    // Configuration writes land directly; write them only while idle.
    always_comb begin
        n_posw = r_posw;
        n_texw = r_texw;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gnto_pkg::CFG_POS_WEIGHT: n_posw = i_cfg_data;
                gnto_pkg::CFG_TEX_WEIGHT: n_texw = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ntri      = r_ntri;
        n_phase     = r_phase;
        n_ovf       = r_ovf;
        n_res_ovf   = r_res_ovf;
        n_used      = r_used;
        n_cur       = r_cur;
        n_j         = r_j;
        n_c         = r_c;
        n_placed    = r_placed;
        n_found     = r_found;
        n_best      = r_best;
        n_best_cost = r_best_cost;
        n_strobe    = 1'b0;
        n_result    = r_result;
        wr_en       = 1'b0;
        issue       = '0;
        tri_total   = r_ntri;
        ovf_total   = r_ovf | full;

        // Keep the running minimum; strict compare leaves ties on the lower index.
        if (cand.valid && (!r_found || cand_cost < r_best_cost)) begin
            n_found     = 1'b1;
            n_best      = cand.j[TW-1:0];
            n_best_cost = cand_cost;
        end

        unique case (r_state)
            gnto_pkg::ST_LOAD: begin
                if (accept) begin
                    if (!full) begin
                        wr_en = 1'b1;
                        if (r_phase == gnto_pkg::CORNER_LAST) begin
                            n_phase   = gnto_pkg::CORNER_FIRST;
                            n_ntri    = r_ntri + NW'(1);
                            tri_total = r_ntri + NW'(1);
                        end else begin
                            n_phase = r_phase + 2'd1;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_vertex.load_end) begin
                        // Close the load; a trailing partial triangle is ignored.
                        n_phase = gnto_pkg::CORNER_FIRST;
                        n_ovf   = 1'b0;
                        if (tri_total == '0) begin
                            n_ntri = '0;
                        end else begin
                            n_strobe                = 1'b1;
                            n_result.triangle_index = '0;
                            n_result.order_end      = (tri_total == NW'(1));
                            n_result.overflow       = ovf_total;
                            n_res_ovf               = ovf_total;
                            n_used                  = '0;
                            n_used[0]               = 1'b1;
                            n_cur                   = '0;
                            n_j                     = '0;
                            n_c                     = gnto_pkg::CORNER_FIRST;
                            n_placed                = NW'(1);
                            n_found                 = 1'b0;
                            if (tri_total == NW'(1)) begin
                                n_ntri = '0;
                                n_used = '0;
                            end else begin
                                n_ntri  = tri_total;
                                n_state = gnto_pkg::ST_SCAN;
                            end
                        end
                    end
                end
            end

            gnto_pkg::ST_SCAN: begin
                // Issue one corner pair per unused candidate cycle; skip used ones.
                issue.valid = ~r_used[r_j];
                issue.first = (r_c == gnto_pkg::CORNER_FIRST);
                issue.last  = (r_c == gnto_pkg::CORNER_LAST);
                issue.j     = gnto_pkg::TRI_IDX_W'(r_j);
                if (r_used[r_j] || r_c == gnto_pkg::CORNER_LAST) begin
                    n_c = gnto_pkg::CORNER_FIRST;
                    if (last_j) begin
                        n_state = gnto_pkg::ST_DRAIN;
                    end else begin
                        n_j = r_j + TW'(1);
                    end
                end else begin
                    n_c = r_c + 2'd1;
                end
            end

            gnto_pkg::ST_DRAIN: begin
                // Wait for the cost pipeline to empty, then commit the pick.
                if (!pending) begin
                    n_cur                   = r_best;
                    n_used[r_best]          = 1'b1;
                    n_strobe                = 1'b1;
                    n_result.triangle_index = gnto_pkg::TRI_IDX_W'(r_best);
                    n_result.order_end      = (r_placed == r_ntri - NW'(1));
                    n_result.overflow       = r_res_ovf;
                    n_j                     = '0;
                    n_c                     = gnto_pkg::CORNER_FIRST;
                    n_found                 = 1'b0;
                    if (r_placed == r_ntri - NW'(1)) begin
                        n_ntri  = '0;
                        n_used  = '0;
                        n_cur   = '0;
                        n_state = gnto_pkg::ST_LOAD;
                    end else begin
                        n_placed = r_placed + NW'(1);
                        n_state  = gnto_pkg::ST_SCAN;
                    end
                end
            end

            default: n_state = gnto_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gnto_pkg::ST_LOAD;
            r_ntri    <= '0;
            r_phase   <= gnto_pkg::CORNER_FIRST;
            r_ovf     <= 1'b0;
            r_res_ovf <= 1'b0;
            r_used    <= '0;
            r_cur     <= '0;
            r_j       <= '0;
            r_c       <= gnto_pkg::CORNER_FIRST;
            r_placed  <= '0;
            r_found   <= 1'b0;
            r_posw    <= gnto_pkg::WEIGHT_W'(1);
            r_texw    <= gnto_pkg::WEIGHT_W'(1);
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ntri    <= n_ntri;
            r_phase   <= n_phase;
            r_ovf     <= n_ovf;
            r_res_ovf <= n_res_ovf;
            r_used    <= n_used;
            r_cur     <= n_cur;
            r_j       <= n_j;
            r_c       <= n_c;
            r_placed  <= n_placed;
            r_found   <= n_found;
            r_posw    <= n_posw;
            r_texw    <= n_texw;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_best      <= n_best;
        r_best_cost <= n_best_cost;
        r_result    <= n_result;
    end

    gnto_store #(
        .DEPTH (VCAP),
        .WIDTH (DW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_data_a),
        .o_rdata_b (rd_data_b)
    );

    gnto_cost #(
        .COORD_BITS (COORD_BITS)
    ) u_cost (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pos_weight (r_posw),
        .i_tex_weight (r_texw),
        .i_issue      (issue),
        .i_rdata_a    (rd_data_a),
        .i_rdata_b    (rd_data_b),
        .o_cand       (cand),
        .o_cand_cost  (cand_cost),
        .o_pending    (pending)
    );

endmodule

>>> src/gnto_checker.sv
// ----------------------------------------------------------------------------
// gnto_checker
// Port-level checks on the ordering block's result and busy behavior.
// ----------------------------------------------------------------------------
`include "greedy_nearest_triangle_order_macros.svh"

module gnto_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input gnto_pkg::t_vertex i_vertex,
    input logic              o_strobe,
    input gnto_pkg::t_result o_result
);

    `GNTO_ASSERT_SAME(a_last_beat_idle, i_clk, i_rst_n, o_strobe && o_result.order_end, !busy, "busy after last result beat")
    `GNTO_ASSERT_SAME(a_mid_beat_busy, i_clk, i_rst_n, o_strobe && !o_result.order_end, busy, "idle before last result beat")
    `GNTO_ASSERT_NEXT(a_plain_vertex_quiet, i_clk, i_rst_n, start && !busy && !i_vertex.load_end, !o_strobe, "result after a plain vertex beat")
    `GNTO_ASSERT_NEXT(a_beats_spaced, i_clk, i_rst_n, o_strobe, !o_strobe, "result beats back to back")

endmodule

bind greedy_nearest_triangle_order gnto_checker u_gnto_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_vertex (i_vertex),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_nearest_triangle_order: streams vertex loads
// of many sizes and coordinate styles under several weight settings, predicts
// the greedy order in a scoreboard class and checks every result beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_TRI      = 64;
    localparam int VERTEX_CAP   = 3 * MAX_TRI;
    localparam int RANDOM_ITEMS = 430;
    localparam int STALL_LIMIT  = 4000;  // watchdog limit, well above the longest single pick
    localparam int DRAIN_CYCLES = 16;    // pipeline drain after the last beat
    localparam int VERTEX_W     = $bits(gnto_pkg::t_vertex);

    // Weight settings for the first phases: the extremes come first.
    localparam bit [gnto_pkg::WEIGHT_W-1:0] POS_PLAN [4] = '{4'd0, 4'd15, 4'd15, 4'd0};
    localparam bit [gnto_pkg::WEIGHT_W-1:0] TEX_PLAN [4] = '{4'd15, 4'd0, 4'd15, 4'd0};

    typedef enum int {
        COORD_FULL,   // any 16-bit value
        COORD_NEAR,   // a few steps around zero, so costs often tie
        COORD_EDGE    // the ends of the signed range, plus zero and +/-1
    } t_coord_style;

    // ------------------------------------------------------------------------
    // Ordering scoreboard: holds the current load and the weights, and queues
    // the triangle order that each closing beat must produce.
    // ------------------------------------------------------------------------
    class triangle_order_scoreboard;
        int                            coords [VERTEX_CAP][gnto_pkg::COORDS];
        int unsigned                   vertices_held;
        bit                            dropped;
        bit [gnto_pkg::WEIGHT_W-1:0]   pos_weight;
        bit [gnto_pkg::WEIGHT_W-1:0]   tex_weight;
        gnto_pkg::t_result             order_q [$];
        int unsigned                   errors;

        function new();
            vertices_held = 0;
            dropped       = 1'b0;
            pos_weight    = 4'd1;
            tex_weight    = 4'd1;
            errors        = 0;
        endfunction

        function void set_weights(bit [gnto_pkg::WEIGHT_W-1:0] pw,
                                  bit [gnto_pkg::WEIGHT_W-1:0] tw);
            pos_weight = pw;
            tex_weight = tw;
        endfunction

        function int unsigned pending();
            return order_q.size();
        endfunction

        // Weighted sum of absolute differences over the 15 corner coordinates.
        function longint unsigned pair_cost(int a, int b);
            longint unsigned sum;
            longint          d;
            sum = 0;
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < gnto_pkg::COORDS; k++) begin
                    d = longint'(coords[a*3+c][k]) - longint'(coords[b*3+c][k]);
                    if (d < 0) d = -d;
                    sum += longint'(d) * ((k < 3) ? pos_weight : tex_weight);
                end
            end
            return sum;
        endfunction

        // Greedy walk from triangle 0; strict less-than keeps the lowest index.
        function void queue_order();
            int                n;
            int                cur;
            int                best;
            bit                found;
            bit                taken [MAX_TRI];
            longint unsigned   best_cost;
            longint unsigned   c;
            gnto_pkg::t_result r;
            n = vertices_held / 3;
            if (n > 0) begin
                foreach (taken[i]) taken[i] = 1'b0;
                taken[0]         = 1'b1;
                cur              = 0;
                r.triangle_index = '0;
                r.order_end      = (n == 1);
                r.overflow       = dropped;
                order_q          = {order_q, r};
                for (int placed = 1; placed < n; placed++) begin
                    found     = 1'b0;
                    best      = 0;
                    best_cost = 0;
                    for (int j = 0; j < n; j++) begin
                        if (!taken[j]) begin
                            c = pair_cost(cur, j);
                            if (!found || c < best_cost) begin
                                found     = 1'b1;
                                best_cost = c;
                                best      = j;
                            end
                        end
                    end
                    taken[best]      = 1'b1;
                    cur              = best;
                    r.triangle_index = gnto_pkg::TRI_IDX_W'(best);
                    r.order_end      = (placed == n - 1);
                    r.overflow       = dropped;
                    order_q          = {order_q, r};
                end
            end
            vertices_held = 0;
            dropped       = 1'b0;
        endfunction

        function void note_vertex(gnto_pkg::t_vertex v);
            if (vertices_held < VERTEX_CAP) begin
                coords[vertices_held][0] = int'(v.pos_x);
                coords[vertices_held][1] = int'(v.pos_y);
                coords[vertices_held][2] = int'(v.pos_z);
                coords[vertices_held][3] = int'(v.tex_u);
                coords[vertices_held][4] = int'(v.tex_v);
                vertices_held++;
            end else begin
                dropped = 1'b1;
            end
            if (v.load_end) queue_order();
        endfunction

        function void check_result(gnto_pkg::t_result got);
            gnto_pkg::t_result want;
            if (order_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: index %0d end %0b overflow %0b",
                             got.triangle_index, got.order_end, got.overflow);
                return;
            end
            want = order_q.pop_front();
            if (got.triangle_index !== want.triangle_index ||
                got.order_end !== want.order_end ||
                got.overflow !== want.overflow) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected index %0d end %0b overflow %0b, ",
                             want.triangle_index, want.order_end, want.overflow,
                             "got index %0d end %0b overflow %0b",
                             got.triangle_index, got.order_end, got.overflow);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    gnto_pkg::t_vertex               i_vertex;
    logic                            o_strobe;
    gnto_pkg::t_result               o_result;
    logic                            i_cfg_we;
    logic [gnto_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gnto_pkg::WEIGHT_W-1:0]   i_cfg_data;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    greedy_nearest_triangle_order dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_vertex   (i_vertex),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    triangle_order_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_count = 0;

    // ------------------------------------------------------------------------
    // Result side: the block cannot be held off, so check every strobed beat.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    // Watchdog: count cycles with no beat moving on any port; bail out on a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [gnto_pkg::FIELD_W-1:0] pick_coord(t_coord_style s);
        case (s)
            COORD_NEAR: return gnto_pkg::FIELD_W'(int'($urandom_range(0, 8)) - 4);
            COORD_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    3:       return 16'shffff;
                    default: return 16'sh0001;
                endcase
            end
            default:    return gnto_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    function automatic gnto_pkg::t_vertex make_vertex(t_coord_style s, bit last);
        gnto_pkg::t_vertex v;
        v.pos_x    = pick_coord(s);
        v.pos_y    = pick_coord(s);
        v.pos_z    = pick_coord(s);
        v.tex_u    = pick_coord(s);
        v.tex_v    = pick_coord(s);
        v.load_end = last;
        return v;
    endfunction

    function automatic gnto_pkg::t_vertex flat_vertex(
        logic signed [gnto_pkg::FIELD_W-1:0] c, bit last);
        gnto_pkg::t_vertex v;
        v.pos_x    = c;
        v.pos_y    = c;
        v.pos_z    = c;
        v.tex_u    = c;
        v.tex_v    = c;
        v.load_end = last;
        return v;
    endfunction

    // Send one vertex beat. The sender runs in bursts; between most bursts drop
    // start for a random gap and put noise on the payload.
    task automatic send_vertex(input gnto_pkg::t_vertex v);
        int                   gap;
        logic [VERTEX_W-1:0]  noise;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            noise    = VERTEX_W'({$urandom, $urandom, $urandom});
            start    <= 1'b0;
            i_vertex <= noise;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_vertex <= v;
        // Hold the beat until an edge sees start with busy low.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_vertex(v);
        items_sent++;
    endtask

    // One load: whole triangles plus a few leftover vertices, closed by load_end.
    task automatic send_load(int tris, int extra, t_coord_style s);
        int total;
        total = tris * 3 + extra;
        for (int i = 0; i < total; i++) send_vertex(make_vertex(s, i == total - 1));
    endtask

    // Drain the block before touching the weights: all beats in, busy low,
    // then a short pause for a closing beat that produced nothing.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weights(bit [gnto_pkg::WEIGHT_W-1:0] pw,
                                 bit [gnto_pkg::WEIGHT_W-1:0] tw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= gnto_pkg::CFG_POS_WEIGHT;
        i_cfg_data <= pw;
        @(posedge i_clk);
        i_cfg_idx  <= gnto_pkg::CFG_TEX_WEIGHT;
        i_cfg_data <= tw;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_weights(pw, tw);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned                 random_from;
        int unsigned                 phase;
        int unsigned                 load_no;
        int                          kind;
        bit [gnto_pkg::WEIGHT_W-1:0] pw;
        bit [gnto_pkg::WEIGHT_W-1:0] tw;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_vertex   <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= gnto_pkg::CFG_POS_WEIGHT;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset weights of one.
        // Lone vertex and a pair: no whole triangle, so no beat comes back.
        send_vertex(flat_vertex(16'sh0000, 1'b1));
        send_vertex(flat_vertex(16'sh0005, 1'b0));
        send_vertex(flat_vertex(-16'sh0005, 1'b1));
        // Single triangle spanning the signed range.
        send_vertex(flat_vertex(16'sh8000, 1'b0));
        send_vertex(flat_vertex(16'sh7fff, 1'b0));
        send_vertex(gnto_pkg::t_vertex'{16'sh7fff, 16'sh8000, 16'sh0000,
                                        16'shffff, 16'sh0001, 1'b1});
        // One triangle plus a trailing partial vertex that must be ignored.
        send_load(1, 1, COORD_EDGE);
        // Four triangles (zero, max, zero, min): the two zero ones come first, then max and min.
        for (int t = 0; t < 4; t++) begin
            for (int c = 0; c < 3; c++) begin
                case (t)
                    1:       send_vertex(flat_vertex(16'sh7fff, 1'b0));
                    3:       send_vertex(flat_vertex(16'sh8000, t == 3 && c == 2));
                    default: send_vertex(flat_vertex(16'sh0000, 1'b0));
                endcase
            end
        end

        // Random part: phases of a few loads, new weights between phases.
        random_from = items_sent;
        phase       = 0;
        load_no     = 0;
        while (items_sent - random_from < RANDOM_ITEMS) begin
            wait_idle();
            if (phase < 4) begin
                pw = POS_PLAN[phase];
                tw = TEX_PLAN[phase];
            end else begin
                pw = gnto_pkg::WEIGHT_W'($urandom_range(0, 15));
                tw = gnto_pkg::WEIGHT_W'($urandom_range(0, 15));
            end
            write_weights(pw, tw);
            repeat ($urandom_range(2, 4)) begin
                kind = $urandom_range(0, 9);
                if (load_no == 3) begin
                    // Fill the store and run past it; the closing vertex is dropped but still closes the load.
                    send_load(MAX_TRI, $urandom_range(1, 3),
                              t_coord_style'($urandom_range(0, 2)));
                end else if (kind == 0) begin
                    send_load(0, $urandom_range(1, 2), t_coord_style'($urandom_range(0, 2)));
                end else if (kind == 1) begin
                    send_load($urandom_range(12, 24), $urandom_range(0, 2),
                              t_coord_style'($urandom_range(0, 2)));
                end else begin
                    send_load($urandom_range(1, 8), $urandom_range(0, 2),
                              t_coord_style'($urandom_range(0, 2)));
                end
                load_no++;
            end
            phase++;
        end

        // Let every expected beat arrive, then give the block time to misbehave.
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
